### rtl/core/adst_pkg.sv
// Shared types, codes and widths of the aging duplicate suppression table.
package adst_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int CMD_W  = 3;
    localparam int ADDR_W = 24;
    localparam int WORD_W = 64;
    localparam int TIME_W = 48;
    localparam int ID_W   = 32;
    localparam int EXP_W  = 24;

    localparam logic [EXP_W-1:0] EXPIRE_RST = 24'd10000;

    // command codes as seen on the cmd port
    localparam logic [CMD_W-1:0] CMD_STORE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REFRESH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SWEEP   = 3'd5;

    typedef enum logic [2:0] {
        OP_STORE,
        OP_LOOKUP,
        OP_REFRESH,
        OP_REMOVE,
        OP_TICK,
        OP_SWEEP,
        OP_NONE
    } op_t;

    typedef enum logic [2:0] {
        ST_STORED,
        ST_DUP,
        ST_FOUND,
        ST_NOTFOUND,
        ST_FULL,
        ST_KEPT,
        ST_REMOVED
    } status_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] packet_word;
        logic [TIME_W-1:0] stamp;
        logic [ID_W-1:0]   match_id;
        logic              force_req;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic              hit;
        logic [WORD_W-1:0] packet;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] time_ms;
        logic [ADDR_W-1:0] address;
    } result_t;

endpackage

### rtl/core/aging_duplicate_suppress_table_top.sv
// Top level of the aging duplicate suppression table.
// Commands enter a two-deep input queue and results leave through a two-deep result queue,
// so either side may stall without holding up the other. The table engine finishes one
// command before it takes the next: as it takes one, it compares the address against all
// ENTRIES stored keys in parallel, picks the slot (match, lowest free slot, or next valid
// slot for a sweep) and reads that slot's packet, id and timestamp memories; in the
// execute state it checks expiry and packet equality, writes back and queues the result.
// A command starts only while the result queue has room. The expiry time may be written
// at any time the block is idle; there is no clearing pass after reset.
module aging_duplicate_suppress_table_top
#(
    parameter int ENTRIES = adst_pkg::ENTRIES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [adst_pkg::CMD_W-1:0]     cmd,
    input  logic [adst_pkg::ADDR_W-1:0]    address,
    input  logic [adst_pkg::WORD_W-1:0]    packet_word,
    input  logic [adst_pkg::TIME_W-1:0]    stamp,
    input  logic [adst_pkg::ID_W-1:0]      match_id,
    input  logic                           force_req,
    output logic                           empty,
    input  logic                           pop,
    output logic [2:0]                     status,
    output logic                           hit,
    output logic [adst_pkg::WORD_W-1:0]    packet_out,
    output logic [adst_pkg::ID_W-1:0]      id_out,
    output logic [adst_pkg::TIME_W-1:0]    time_out,
    output logic [adst_pkg::ADDR_W-1:0]    address_out,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [adst_pkg::EXP_W-1:0]     expire_after
);

    adst_pkg::item_t   item;
    logic              item_ready;
    logic              item_take;
    adst_pkg::result_t res;
    logic              res_push;
    logic              out_room;

    adst_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .address     (address),
        .packet_word (packet_word),
        .stamp       (stamp),
        .match_id    (match_id),
        .force_req   (force_req),
        .item        (item),
        .item_ready  (item_ready),
        .item_take   (item_take)
    );

    adst_back #(.ENTRIES(ENTRIES)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_ready   (item_ready),
        .item_take    (item_take),
        .out_room     (out_room),
        .res          (res),
        .res_push     (res_push),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .expire_after (expire_after)
    );

    adst_outq u_outq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .res         (res),
        .res_push    (res_push),
        .out_room    (out_room),
        .pop         (pop),
        .empty       (empty),
        .status      (status),
        .hit         (hit),
        .packet_out  (packet_out),
        .id_out      (id_out),
        .time_out    (time_out),
        .address_out (address_out)
    );

endmodule

### rtl/core/adst_front.sv
// Input queue: accepts commands, decodes them and holds up to two for the back end.
module adst_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [adst_pkg::CMD_W-1:0]     cmd,
    input  logic [adst_pkg::ADDR_W-1:0]    address,
    input  logic [adst_pkg::WORD_W-1:0]    packet_word,
    input  logic [adst_pkg::TIME_W-1:0]    stamp,
    input  logic [adst_pkg::ID_W-1:0]      match_id,
    input  logic                           force_req,
    output adst_pkg::item_t                item,
    output logic                           item_ready,
    input  logic                           item_take
);

    adst_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            accept;
    adst_pkg::op_t   op;

    always_comb
    begin
        case (cmd)
            adst_pkg::CMD_STORE:   op = adst_pkg::OP_STORE;
            adst_pkg::CMD_LOOKUP:  op = adst_pkg::OP_LOOKUP;
            adst_pkg::CMD_REFRESH: op = adst_pkg::OP_REFRESH;
            adst_pkg::CMD_REMOVE:  op = adst_pkg::OP_REMOVE;
            adst_pkg::CMD_TICK:    op = adst_pkg::OP_TICK;
            adst_pkg::CMD_SWEEP:   op = adst_pkg::OP_SWEEP;
            default:               op = adst_pkg::OP_NONE;
        endcase
    end

    assign full       = (count_reg == 2'd2);
    assign accept     = push && !full;
    assign item_ready = (count_reg != 2'd0);
    assign item       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg[wr_ptr_reg] <= '{op: op, address: address, packet_word: packet_word,
                                       stamp: stamp, match_id: match_id,
                                       force_req: force_req};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (item_take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, accept} - {1'b0, item_take};
        end
    end

endmodule

### rtl/core/adst_back.sv
// Table engine: key compare and slot select, then decision and write-back.
module adst_back
#(
    parameter int ENTRIES = adst_pkg::ENTRIES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  adst_pkg::item_t                item,
    input  logic                           item_ready,
    output logic                           item_take,
    input  logic                           out_room,
    output adst_pkg::result_t              res,
    output logic                           res_push,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [adst_pkg::EXP_W-1:0]     expire_after
);

    localparam int IDX_W = $clog2(ENTRIES);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                        state_reg;
    logic [ENTRIES-1:0]            valid_reg;
    logic [adst_pkg::ADDR_W-1:0]   key_reg [ENTRIES];
    logic [adst_pkg::ID_W-1:0]     next_id_reg;
    logic [adst_pkg::TIME_W-1:0]   now_reg;
    logic [IDX_W-1:0]              sweep_ptr_reg;
    logic [adst_pkg::EXP_W-1:0]    expire_reg;

    adst_pkg::item_t               cur_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic                          hit_reg;
    logic                          free_reg;
    logic                          swept_reg;
    logic [adst_pkg::ADDR_W-1:0]   key_rd_reg;

    // entry payload memories
    logic [adst_pkg::WORD_W-1:0]   pkt_mem  [ENTRIES];
    logic [adst_pkg::ID_W-1:0]     id_mem   [ENTRIES];
    logic [adst_pkg::TIME_W-1:0]   time_mem [ENTRIES];
    logic [adst_pkg::WORD_W-1:0]   pkt_rd_reg;
    logic [adst_pkg::ID_W-1:0]     id_rd_reg;
    logic [adst_pkg::TIME_W-1:0]   time_rd_reg;

    // slot search
    logic [IDX_W-1:0]              match_idx;
    logic                          match_any;
    logic [IDX_W-1:0]              free_idx;
    logic                          free_any;
    logic [IDX_W-1:0]              up_idx;
    logic                          up_any;
    logic [IDX_W-1:0]              low_idx;
    logic [IDX_W-1:0]              sweep_idx;
    logic                          sweep_any;
    logic [IDX_W-1:0]              rd_idx;

    // execute
    logic [adst_pkg::TIME_W:0]     limit;
    logic                          expired;
    logic                          wr_all;
    logic                          wr_time;
    logic                          clr_valid;
    logic                          adv_id;
    logic                          adv_now;
    logic                          adv_ptr;
    logic [adst_pkg::TIME_W-1:0]   new_time;
    logic [adst_pkg::TIME_W-1:0]   now_inc;
    logic [IDX_W-1:0]              ptr_next;

    assign item_take = (state_reg == S_IDLE) && item_ready && out_room;
    assign cfg_ready = 1'b1;
    assign res_push  = (state_reg == S_EXEC);

    always_comb
    begin
        match_idx = '0;
        match_any = 1'b0;
        free_idx  = '0;
        free_any  = 1'b0;
        up_idx    = '0;
        up_any    = 1'b0;
        low_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (key_reg[i] == item.address))
            begin
                match_idx = IDX_W'(i);
                match_any = 1'b1;
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
                free_any = 1'b1;
            end
            if (valid_reg[i] && (IDX_W'(i) >= sweep_ptr_reg))
            begin
                up_idx = IDX_W'(i);
                up_any = 1'b1;
            end
            if (valid_reg[i])
            begin
                low_idx = IDX_W'(i);
            end
        end
        // wrap round to the lowest valid slot when nothing lies at or above the pointer
        sweep_idx = up_any ? up_idx : low_idx;
        sweep_any = |valid_reg;

        case (item.op)
            adst_pkg::OP_SWEEP: rd_idx = sweep_idx;
            adst_pkg::OP_STORE: rd_idx = match_any ? match_idx : free_idx;
            default:            rd_idx = match_idx;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            pkt_rd_reg  <= pkt_mem[rd_idx];
            id_rd_reg   <= id_mem[rd_idx];
            time_rd_reg <= time_mem[rd_idx];
        end
        if (wr_all)
        begin
            pkt_mem[idx_reg] <= cur_reg.packet_word;
            id_mem[idx_reg]  <= next_id_reg;
        end
        if (wr_all || wr_time)
        begin
            time_mem[idx_reg] <= new_time;
        end
    end

    always_comb
    begin
        limit    = {1'b0, time_rd_reg} + (adst_pkg::TIME_W + 1)'(expire_reg);
        expired  = {1'b0, now_reg} > limit;
        now_inc  = now_reg + 1'b1;
        ptr_next = (idx_reg == IDX_W'(ENTRIES - 1)) ? '0 : idx_reg + 1'b1;

        wr_all    = 1'b0;
        wr_time   = 1'b0;
        clr_valid = 1'b0;
        adv_id    = 1'b0;
        adv_now   = 1'b0;
        adv_ptr   = 1'b0;
        new_time  = now_reg;

        res = '{status: adst_pkg::ST_NOTFOUND, hit: 1'b0, packet: '0, id: '0,
                time_ms: '0, address: '0};

        case (cur_reg.op)
            adst_pkg::OP_STORE:
            begin
                if (hit_reg && !expired && (pkt_rd_reg == cur_reg.packet_word))
                begin
                    res = '{status: adst_pkg::ST_DUP, hit: 1'b1, packet: pkt_rd_reg,
                            id: id_rd_reg, time_ms: time_rd_reg, address: '0};
                end
                else if (!hit_reg && !free_reg)
                begin
                    res.status = adst_pkg::ST_FULL;
                end
                else
                begin
                    new_time = (cur_reg.stamp != '0) ? cur_reg.stamp : now_reg;
                    wr_all   = res_push;
                    adv_id   = res_push;
                    res = '{status: adst_pkg::ST_STORED, hit: hit_reg,
                            packet: cur_reg.packet_word, id: next_id_reg,
                            time_ms: new_time, address: '0};
                end
            end
            adst_pkg::OP_LOOKUP:
            begin
                if (hit_reg)
                begin
                    res = '{status: adst_pkg::ST_FOUND, hit: 1'b1, packet: pkt_rd_reg,
                            id: id_rd_reg, time_ms: time_rd_reg, address: '0};
                end
            end
            adst_pkg::OP_REFRESH:
            begin
                if (hit_reg)
                begin
                    wr_time = res_push;
                    res = '{status: adst_pkg::ST_FOUND, hit: 1'b1, packet: pkt_rd_reg,
                            id: id_rd_reg, time_ms: now_reg, address: '0};
                end
            end
            adst_pkg::OP_REMOVE:
            begin
                if (hit_reg)
                begin
                    res = '{status: adst_pkg::ST_KEPT, hit: 1'b1, packet: pkt_rd_reg,
                            id: id_rd_reg, time_ms: time_rd_reg, address: '0};
                    if ((id_rd_reg == cur_reg.match_id) && (cur_reg.force_req || expired))
                    begin
                        res.status = adst_pkg::ST_REMOVED;
                        clr_valid  = res_push;
                    end
                end
            end
            adst_pkg::OP_TICK:
            begin
                adv_now = res_push;
                res.status  = adst_pkg::ST_STORED;
                res.time_ms = now_inc;
            end
            adst_pkg::OP_SWEEP:
            begin
                if (swept_reg)
                begin
                    adv_ptr = res_push;
                    res = '{status: adst_pkg::ST_KEPT, hit: 1'b1, packet: pkt_rd_reg,
                            id: id_rd_reg, time_ms: time_rd_reg, address: key_rd_reg};
                    if (expired)
                    begin
                        res.status = adst_pkg::ST_REMOVED;
                        clr_valid  = res_push;
                    end
                end
            end
            default:
            begin
                res.status = adst_pkg::ST_NOTFOUND;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            cur_reg    <= item;
            idx_reg    <= rd_idx;
            hit_reg    <= match_any;
            free_reg   <= free_any;
            swept_reg  <= sweep_any;
            key_rd_reg <= key_reg[sweep_idx];
        end
        if (wr_all)
        begin
            key_reg[idx_reg] <= cur_reg.address;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            next_id_reg   <= '0;
            now_reg       <= '0;
            sweep_ptr_reg <= '0;
            expire_reg    <= adst_pkg::EXPIRE_RST;
        end
        else
        begin
            if (cfg_valid)
            begin
                expire_reg <= expire_after;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (item_take)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (wr_all)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (clr_valid)
            begin
                valid_reg[idx_reg] <= 1'b0;
            end
            if (adv_id)
            begin
                next_id_reg <= next_id_reg + 1'b1;
            end
            if (adv_now)
            begin
                now_reg <= now_inc;
            end
            if (adv_ptr)
            begin
                sweep_ptr_reg <= ptr_next;
            end
        end
    end

endmodule

### rtl/core/adst_outq.sv
// Result queue: holds up to two finished results until they are popped.
module adst_outq
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  adst_pkg::result_t              res,
    input  logic                           res_push,
    output logic                           out_room,
    input  logic                           pop,
    output logic                           empty,
    output logic [2:0]                     status,
    output logic                           hit,
    output logic [adst_pkg::WORD_W-1:0]    packet_out,
    output logic [adst_pkg::ID_W-1:0]      id_out,
    output logic [adst_pkg::TIME_W-1:0]    time_out,
    output logic [adst_pkg::ADDR_W-1:0]    address_out
);

    adst_pkg::result_t entry_reg [2];
    adst_pkg::result_t head;
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              take;

    assign empty    = (count_reg == 2'd0);
    assign out_room = (count_reg != 2'd2);
    assign take     = pop && !empty;
    assign head     = entry_reg[rd_ptr_reg];

    assign status      = head.status;
    assign hit         = head.hit;
    assign packet_out  = head.packet;
    assign id_out      = head.id;
    assign time_out    = head.time_ms;
    assign address_out = head.address;

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            entry_reg[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (res_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, res_push} - {1'b0, take};
        end
    end

endmodule
